// ===== rtl/core/ldgm_pkg.sv =====
// ldgm_pkg: shared types, constants and codes for the gate mutex node
// depends on nothing
package ldgm_pkg;

    localparam int QUEUE_DEPTH = 16;
    localparam int QIDX_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);
    localparam int FIFO_DEPTH  = 2;

    localparam logic [31:0] STAMP_MAX = 32'hFFFF_FFFF;
    localparam logic [6:0]  ACK_MAX   = 7'd127;

    // event kinds
    localparam logic [2:0] KIND_OWN_REQ = 3'd0;
    localparam logic [2:0] KIND_REM_REQ = 3'd1;
    localparam logic [2:0] KIND_ACK     = 3'd2;
    localparam logic [2:0] KIND_RELEASE = 3'd3;
    localparam logic [2:0] KIND_LEAVE   = 3'd4;

    // outgoing message kinds
    localparam logic [1:0] SEND_NONE    = 2'd0;
    localparam logic [1:0] SEND_REQUEST = 2'd1;
    localparam logic [1:0] SEND_REPLY   = 2'd2;
    localparam logic [1:0] SEND_RELEASE = 2'd3;

    // configuration register indexes
    localparam logic [1:0] CFG_OWN_RANK   = 2'd0;
    localparam logic [1:0] CFG_NODE_COUNT = 2'd1;
    localparam logic [1:0] CFG_OWN_DIR    = 2'd2;
    localparam logic [1:0] CFG_GATE_CAP   = 2'd3;

    typedef struct packed {
        logic [2:0]  kind;
        logic [31:0] msg_stamp;
        logic [5:0]  msg_sender;
        logic [1:0]  msg_direction;
    } in_item_t;

    typedef struct packed {
        logic [1:0]  send_kind;
        logic [5:0]  send_dest;
        logic [31:0] send_stamp;
        logic [1:0]  send_direction;
        logic        granted;
        logic [1:0]  gate_now;
        logic        dropped;
    } out_item_t;

    typedef struct packed {
        logic [31:0] stamp;
        logic [5:0]  rank;
        logic [1:0]  dir;
    } entry_t;

    // queue operation handed from front to back
    typedef enum logic [1:0] {
        OP_NONE,
        OP_INSERT,
        OP_REMOVE
    } op_t;

    // classified command between front and back
    typedef struct packed {
        op_t         op;
        entry_t      ent;
        logic [5:0]  rm_rank;
        logic [1:0]  send_kind;
        logic [5:0]  send_dest;
        logic [31:0] send_stamp;
        logic [1:0]  send_direction;
        logic [6:0]  ack_total;
    } cmd_t;

    typedef struct packed {
        logic [5:0] own_rank;
        logic [6:0] node_count;
        logic [1:0] own_direction;
        logic [4:0] pass_limit;
    } cfg_t;

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_SEARCH,
        BK_SHIFT,
        BK_SCAN,
        BK_DONE
    } bk_state_t;

    function automatic logic [31:0] sat_inc(input logic [31:0] v);
        return (v == STAMP_MAX) ? v : v + 32'd1;
    endfunction

endpackage

// ===== rtl/core/lamport_direction_gate_mutex.sv =====
// lamport_direction_gate_mutex: top level of one Lamport mutex node at a gate
// depends on ldgm_pkg, ldgm_front, ldgm_fifo, ldgm_back
//
// Usage:
//   Events enter on start/item; an event is taken when start is high and busy
//   is low. Every event yields one result beat on result with done high for
//   exactly one cycle; the receiver cannot stall it.
//   Configuration is written on cfg_valid/cfg_ready with cfg_index and
//   cfg_data; cfg_ready is always high. Write only while the block is idle.
//   Processing: the front classifies in the accept cycle and queues a command;
//   the back walks the request queue one entry a cycle to find the insert or
//   removal point (other events skip the walk), shifts the queue there when an
//   entry goes in or out, then scans the queue for the grant. busy is high from
//   acceptance until the result has been shown and falls the cycle after it, so
//   a new event is taken only after the result of the last one has been shown.
//   Reset clears the clock, ack count, queue fill and gate direction and
//   restores the configuration defaults; queue entries are not cleared.
module lamport_direction_gate_mutex (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    output logic                 busy,
    input  ldgm_pkg::in_item_t   item,
    output logic                 done,
    output ldgm_pkg::out_item_t  result,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [1:0]           cfg_index,
    input  logic [6:0]           cfg_data
);
    import ldgm_pkg::*;

    cfg_t cfg_reg;
    cmd_t f_cmd, b_cmd;
    logic take, pop, nemp, full, bidle;
    logic pend_reg;

    assign cfg_ready = 1'b1;
    assign busy      = pend_reg;
    assign take      = start && !busy;

    // config registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cfg_reg <= '{6'd0, 7'd2, 2'd1, 5'd2};
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_OWN_RANK:   cfg_reg.own_rank      <= cfg_data[5:0];
                CFG_NODE_COUNT: cfg_reg.node_count    <= cfg_data;
                CFG_OWN_DIR:    cfg_reg.own_direction <= cfg_data[1:0];
                CFG_GATE_CAP:   cfg_reg.pass_limit    <= cfg_data[4:0];
                default:        cfg_reg <= cfg_reg;
            endcase
        end
    end

    // one event in flight
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pend_reg <= 1'b0;
        else if (take)
            pend_reg <= 1'b1;
        else if (done)
            pend_reg <= 1'b0;
    end

    ldgm_front u_front (
        .clk(clk), .rst_n(rst_n), .take(take), .item(item), .cfg(cfg_reg), .cmd(f_cmd)
    );

    ldgm_fifo u_fifo (
        .clk(clk), .rst_n(rst_n), .push(take), .wdata(f_cmd), .pop(pop),
        .rdata(b_cmd), .not_empty(nemp), .full(full)
    );

    ldgm_back u_back (
        .clk(clk), .rst_n(rst_n), .cmd_valid(nemp), .cmd(b_cmd), .cfg(cfg_reg),
        .cmd_pop(pop), .idle(bidle), .res_valid(done), .res(result)
    );

`ifndef SYNTHESIS
    // a result only appears for an event in flight
    a_done_pending: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> pend_reg) else $error("result without event");
    // queue never overflows
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(take && full)) else $error("command queue overflow");
    // back part idle when nothing is pending
    a_idle: assert property (@(posedge clk) disable iff (!rst_n)
        !pend_reg |-> bidle) else $error("back busy with nothing pending");
`endif

endmodule

// ===== rtl/core/ldgm_front.sv =====
// ldgm_front: accepts events, keeps clock and ack count, classifies into commands
// depends on ldgm_pkg
module ldgm_front (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              take,
    input  ldgm_pkg::in_item_t item,
    input  ldgm_pkg::cfg_t    cfg,
    output ldgm_pkg::cmd_t    cmd
);
    import ldgm_pkg::*;

    logic [31:0] clock_reg, clock_next;
    logic [6:0]  ack_reg, ack_next;
    logic [31:0] merged;

    // merge received stamp
    assign merged = sat_inc((item.msg_stamp > clock_reg) ? item.msg_stamp : clock_reg);

    // classify event
    always_comb
    begin
        clock_next = clock_reg;
        ack_next   = ack_reg;
        cmd        = '0;
        cmd.op     = OP_NONE;
        case (item.kind)
            KIND_OWN_REQ:
            begin
                ack_next            = '0;
                clock_next          = sat_inc(clock_reg);
                cmd.op              = OP_INSERT;
                cmd.ent             = '{clock_next, cfg.own_rank, cfg.own_direction};
                cmd.send_kind       = SEND_REQUEST;
                cmd.send_stamp      = clock_next;
                cmd.send_direction  = cfg.own_direction;
            end
            KIND_REM_REQ:
            begin
                clock_next     = sat_inc(merged);
                cmd.op         = OP_INSERT;
                cmd.ent        = '{item.msg_stamp, item.msg_sender, item.msg_direction};
                cmd.send_kind  = SEND_REPLY;
                cmd.send_dest  = item.msg_sender;
                cmd.send_stamp = clock_next;
            end
            KIND_ACK:
            begin
                clock_next = merged;
                if (ack_reg != ACK_MAX)
                    ack_next = ack_reg + 7'd1;
            end
            KIND_RELEASE:
            begin
                clock_next  = merged;
                cmd.op      = OP_REMOVE;
                cmd.rm_rank = item.msg_sender;
            end
            KIND_LEAVE:
            begin
                clock_next     = sat_inc(clock_reg);
                cmd.op         = OP_REMOVE;
                cmd.rm_rank    = cfg.own_rank;
                cmd.send_kind  = SEND_RELEASE;
                cmd.send_stamp = clock_next;
            end
            default:
            begin
            end
        endcase
        cmd.ack_total = ack_next;
    end

    // clock and ack registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clock_reg <= '0;
            ack_reg   <= '0;
        end
        else if (take)
        begin
            clock_reg <= clock_next;
            ack_reg   <= ack_next;
        end
    end

endmodule

// ===== rtl/core/ldgm_fifo.sv =====
// ldgm_fifo: short command queue between front and back
// depends on ldgm_pkg
module ldgm_fifo (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  ldgm_pkg::cmd_t wdata,
    input  logic           pop,
    output ldgm_pkg::cmd_t rdata,
    output logic           not_empty,
    output logic           full
);
    import ldgm_pkg::*;

    localparam int PW = $clog2(FIFO_DEPTH);

    cmd_t            mem_reg [FIFO_DEPTH];
    logic [PW-1:0]   wp_reg, rp_reg;
    logic [PW:0]     cnt_reg;

    assign rdata     = mem_reg[rp_reg];
    assign not_empty = (cnt_reg != '0);
    assign full      = (cnt_reg == (PW+1)'(FIFO_DEPTH));

    // storage
    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wp_reg] <= wdata;
    end

    // pointers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (push)
                wp_reg <= wp_reg + PW'(1);
            if (pop)
                rp_reg <= rp_reg + PW'(1);
            cnt_reg <= cnt_reg + (PW+1)'(push) - (PW+1)'(pop);
        end
    end

endmodule

// ===== rtl/core/ldgm_back.sv =====
// ldgm_back: sorted queue, insert/remove by stepping, gate and grant scan
// depends on ldgm_pkg
module ldgm_back (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cmd_valid,
    input  ldgm_pkg::cmd_t      cmd,
    input  ldgm_pkg::cfg_t      cfg,
    output logic                cmd_pop,
    output logic                idle,
    output logic                res_valid,
    output ldgm_pkg::out_item_t res
);
    import ldgm_pkg::*;

    bk_state_t        st_reg, st_next;
    entry_t           q_reg [QUEUE_DEPTH];
    logic [QCNT_W-1:0] fill_reg;
    logic [QCNT_W-1:0] pos_reg;
    logic [1:0]       gate_reg;
    logic [4:0]       seen_reg;
    logic             found_reg, hit_reg;
    logic             drop_reg;
    cmd_t             cur_reg;
    logic             res_v_reg;
    out_item_t        res_reg;

    entry_t           pe;
    logic             pos_end;
    logic             ins_before;
    logic [6:0]       need;
    logic [1:0]       head_dir;
    logic             scan_use;

    assign pos_end    = (pos_reg >= fill_reg);
    assign pe         = q_reg[pos_reg[QIDX_W-1:0]];
    assign ins_before = (cur_reg.ent.stamp < pe.stamp) ||
                        ((cur_reg.ent.stamp == pe.stamp) && (cur_reg.ent.rank < pe.rank));
    assign need       = (cfg.node_count == 7'd0) ? 7'd0 : cfg.node_count - 7'd1;
    assign head_dir   = (fill_reg == '0) ? 2'd0 : q_reg[0].dir;
    // entry counts towards the grant scan
    assign scan_use   = !pos_end && (pe.dir == head_dir) && !(found_reg && pos_reg != '0);

    assign idle      = (st_reg == BK_IDLE);
    assign cmd_pop   = (st_reg == BK_IDLE) && cmd_valid;
    assign res_valid = res_v_reg;
    assign res       = res_reg;

    // next state
    always_comb
    begin
        st_next = st_reg;
        unique case (st_reg)
            BK_IDLE:   if (cmd_valid) st_next = BK_SEARCH;
            BK_SEARCH:
            begin
                if (cur_reg.op == OP_INSERT)
                begin
                    if (fill_reg >= QCNT_W'(QUEUE_DEPTH)) st_next = BK_SCAN;
                    else if (pos_end || ins_before)      st_next = BK_SHIFT;
                end
                else if (cur_reg.op == OP_REMOVE)
                begin
                    if (pos_end) st_next = BK_SCAN;
                    else if (pe.rank == cur_reg.rm_rank) st_next = BK_SHIFT;
                end
                else
                    st_next = BK_SCAN;
            end
            BK_SHIFT:  st_next = BK_SCAN;
            BK_SCAN:   if (pos_end) st_next = BK_DONE;
            BK_DONE:   st_next = BK_IDLE;
            default:   st_next = BK_IDLE;
        endcase
    end

    // datapath and outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg  <= '0;
            gate_reg  <= '0;
            res_v_reg <= 1'b0;
        end
        else
        begin
            res_v_reg <= 1'b0;
            if (st_reg == BK_SHIFT)
            begin
                if (cur_reg.op == OP_INSERT)
                    fill_reg <= fill_reg + QCNT_W'(1);
                else
                    fill_reg <= fill_reg - QCNT_W'(1);
            end
            if (st_reg == BK_DONE)
            begin
                res_v_reg <= 1'b1;
            end
            if (st_reg == BK_SCAN && pos_reg == '0)
                gate_reg <= head_dir;
        end
    end

    // queue shifting: one parallel shift at the found position
    always_ff @(posedge clk)
    begin
        if (st_reg == BK_SHIFT)
        begin
            for (int i = 0; i < QUEUE_DEPTH; i++)
            begin
                if (cur_reg.op == OP_INSERT)
                begin
                    if (QCNT_W'(i) == pos_reg)
                        q_reg[i] <= cur_reg.ent;
                    else if (QCNT_W'(i) > pos_reg && QCNT_W'(i) <= fill_reg && i > 0)
                        q_reg[i] <= q_reg[(i == 0) ? 0 : i - 1];
                end
                else if (QCNT_W'(i) >= pos_reg && i < QUEUE_DEPTH - 1)
                    q_reg[i] <= q_reg[(i == QUEUE_DEPTH - 1) ? i : i + 1];
            end
        end
    end

    // sequencing registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            st_reg <= BK_IDLE;
        else
            st_reg <= st_next;
    end

    always_ff @(posedge clk)
    begin
        unique case (st_reg)
            BK_IDLE:
            begin
                cur_reg  <= cmd;
                pos_reg  <= '0;
                drop_reg <= 1'b0;
            end
            BK_SEARCH:
            begin
                if (st_next == BK_SCAN)
                begin
                    pos_reg  <= '0;
                    drop_reg <= (cur_reg.op == OP_INSERT);
                end
                else if (st_next == BK_SEARCH)
                    pos_reg <= pos_reg + QCNT_W'(1);
            end
            BK_SHIFT:  pos_reg <= '0;
            BK_SCAN:
            begin
                if (!pos_end)
                    pos_reg <= pos_reg + QCNT_W'(1);
                if (scan_use)
                begin
                    if (pe.rank == cfg.own_rank)
                    begin
                        found_reg <= 1'b1;
                        hit_reg   <= (((pos_reg == '0) ? 5'd0 : seen_reg) <
                                      cfg.pass_limit);
                    end
                    else
                    begin
                        seen_reg <= ((pos_reg == '0) ? 5'd0 : seen_reg) + 5'd1;
                        if (pos_reg == '0)
                        begin
                            found_reg <= 1'b0;
                            hit_reg   <= 1'b0;
                        end
                    end
                end
                else if (pos_reg == '0)
                begin
                    seen_reg  <= '0;
                    found_reg <= 1'b0;
                    hit_reg   <= 1'b0;
                end
            end
            BK_DONE:
            begin
                res_reg.send_kind      <= cur_reg.send_kind;
                res_reg.send_dest      <= cur_reg.send_dest;
                res_reg.send_stamp     <= cur_reg.send_stamp;
                res_reg.send_direction <= cur_reg.send_direction;
                res_reg.gate_now       <= gate_reg;
                res_reg.dropped        <= drop_reg;
                res_reg.granted        <= (gate_reg != 2'd0) && (fill_reg != '0) &&
                                          (cfg.own_direction == gate_reg) &&
                                          found_reg && hit_reg &&
                                          (cur_reg.ack_total >= need);
            end
            default:
            begin
            end
        endcase
    end

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 100ps
// tb: self-checking bench for the lamport gate mutex node
// depends on ldgm_pkg and lamport_direction_gate_mutex
module tb;
    import ldgm_pkg::*;

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    in_item_t    item;
    logic        done;
    out_item_t   result;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [1:0]  cfg_index;
    logic [6:0]  cfg_data;

    lamport_direction_gate_mutex dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .item(item),
        .done(done), .result(result), .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    // node model state
    logic [5:0]  m_rank;
    logic [6:0]  m_nodes;
    logic [1:0]  m_dir;
    logic [4:0]  m_cap;
    logic [31:0] m_clock;
    logic [6:0]  m_acks;
    entry_t      m_queue [QUEUE_DEPTH];
    int          m_fill;
    logic [1:0]  m_gate;

    out_item_t   pending_results [$];
    int          fail_count;

    // directed rows
    typedef struct {
        in_item_t  beat;
        bit        typed;
        out_item_t want;
    } row_t;
    row_t rows [$];

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    function automatic logic [31:0] stamp_bump(input logic [31:0] v);
        return (v == 32'hFFFF_FFFF) ? v : v + 32'd1;
    endfunction

    function automatic bit goes_first(input entry_t a, input entry_t b);
        if (a.stamp != b.stamp)
            return a.stamp < b.stamp;
        return a.rank < b.rank;
    endfunction

    function automatic bit enqueue_request(input entry_t e);
        int pos;
        if (m_fill >= QUEUE_DEPTH)
            return 1'b1;
        pos = 0;
        while (pos < m_fill && !goes_first(e, m_queue[pos]))
            pos++;
        for (int i = m_fill; i > pos; i--)
            m_queue[i] = m_queue[i-1];
        m_queue[pos] = e;
        m_fill++;
        return 1'b0;
    endfunction

    function automatic void dequeue_rank(input logic [5:0] r);
        int i;
        for (i = 0; i < m_fill; i++)
            if (m_queue[i].rank == r)
                break;
        if (i >= m_fill)
            return;
        for (; i + 1 < m_fill; i++)
            m_queue[i] = m_queue[i+1];
        m_fill--;
    endfunction

    function automatic bit entry_allowed();
        int seen;
        bit front;
        logic [6:0] need;
        need = (m_nodes == 0) ? 7'd0 : m_nodes - 7'd1;
        if (m_gate == 2'd0 || m_fill == 0 || m_queue[0].dir != m_gate || m_dir != m_gate)
            return 1'b0;
        seen = 0;
        front = 1'b0;
        for (int i = 0; i < m_fill; i++)
        begin
            if (m_queue[i].dir == m_gate)
            begin
                if (m_queue[i].rank == m_rank)
                begin
                    front = (seen < m_cap);
                    break;
                end
                seen++;
            end
        end
        return front && (m_acks >= need);
    endfunction

    // advance the node model by one event and return its outgoing beat
    function automatic out_item_t node_step(input in_item_t it);
        out_item_t o;
        entry_t e;
        o = '0;
        if (it.kind inside {KIND_REM_REQ, KIND_ACK, KIND_RELEASE})
        begin
            if (it.msg_stamp > m_clock)
                m_clock = it.msg_stamp;
            m_clock = stamp_bump(m_clock);
        end
        case (it.kind)
            KIND_OWN_REQ:
            begin
                m_acks = '0;
                m_clock = stamp_bump(m_clock);
                o.send_kind = SEND_REQUEST;
                o.send_stamp = m_clock;
                o.send_direction = m_dir;
                e = '{stamp: m_clock, rank: m_rank, dir: m_dir};
                o.dropped = enqueue_request(e);
                m_gate = (m_fill == 0) ? 2'd0 : m_queue[0].dir;
            end
            KIND_REM_REQ:
            begin
                e = '{stamp: it.msg_stamp, rank: it.msg_sender, dir: it.msg_direction};
                o.dropped = enqueue_request(e);
                m_clock = stamp_bump(m_clock);
                o.send_kind = SEND_REPLY;
                o.send_dest = it.msg_sender;
                o.send_stamp = m_clock;
                m_gate = (m_fill == 0) ? 2'd0 : m_queue[0].dir;
            end
            KIND_ACK:
                if (m_acks < ACK_MAX)
                    m_acks++;
            KIND_RELEASE:
            begin
                dequeue_rank(it.msg_sender);
                m_gate = (m_fill == 0) ? 2'd0 : m_queue[0].dir;
            end
            KIND_LEAVE:
            begin
                dequeue_rank(m_rank);
                m_gate = (m_fill == 0) ? 2'd0 : m_queue[0].dir;
                m_clock = stamp_bump(m_clock);
                o.send_kind = SEND_RELEASE;
                o.send_stamp = m_clock;
            end
            default: ;
        endcase
        o.granted = entry_allowed();
        o.gate_now = m_gate;
        return o;
    endfunction

    // compare each result beat against the oldest expectation
    always @(posedge clk)
    begin
        out_item_t w;
        if (rst_n && done)
        begin
            if (pending_results.size() == 0)
            begin
                $error("result beat with nothing expected");
                fail_count++;
            end
            else
            begin
                w = pending_results.pop_front();
                if (result.send_kind !== w.send_kind)
                begin
                    $error("send_kind exp %0d got %0d", w.send_kind, result.send_kind);
                    fail_count++;
                end
                if (result.send_dest !== w.send_dest)
                begin
                    $error("send_dest exp %0d got %0d", w.send_dest, result.send_dest);
                    fail_count++;
                end
                if (result.send_stamp !== w.send_stamp)
                begin
                    $error("send_stamp exp %0h got %0h", w.send_stamp, result.send_stamp);
                    fail_count++;
                end
                if (result.send_direction !== w.send_direction)
                begin
                    $error("send_direction exp %0d got %0d", w.send_direction,
                           result.send_direction);
                    fail_count++;
                end
                if (result.granted !== w.granted)
                begin
                    $error("granted exp %0d got %0d", w.granted, result.granted);
                    fail_count++;
                end
                if (result.gate_now !== w.gate_now)
                begin
                    $error("gate_now exp %0d got %0d", w.gate_now, result.gate_now);
                    fail_count++;
                end
                if (result.dropped !== w.dropped)
                begin
                    $error("dropped exp %0d got %0d", w.dropped, result.dropped);
                    fail_count++;
                end
            end
        end
    end

    task automatic idle_burst(input bit allow);
        if (allow && $urandom_range(0, 3) == 0)
            repeat ($urandom_range(1, 5)) @(posedge clk);
    endtask

    // one event beat; typed rows check the hand-written result too
    task automatic send_event(input in_item_t it, input bit typed, input out_item_t want,
                              input bit gaps);
        out_item_t p;
        idle_burst(gaps);
        p = node_step(it);
        if (typed && p !== want)
        begin
            $error("typed row exp %h model %h", want, p);
            fail_count++;
        end
        pending_results.push_back(p);
        start <= 1'b1;
        item <= it;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        start <= 1'b0;
        // wait for the result so the next start sees a settled busy
        while (pending_results.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [6:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        case (idx)
            CFG_OWN_RANK:   m_rank = val[5:0];
            CFG_NODE_COUNT: m_nodes = val;
            CFG_OWN_DIR:    m_dir = val[1:0];
            default:        m_cap = val[4:0];
        endcase
    endtask

    function automatic in_item_t make_event(input logic [2:0] k, input logic [31:0] s,
                                            input logic [5:0] r, input logic [1:0] d);
        in_item_t it;
        it.kind = k;
        it.msg_stamp = s;
        it.msg_sender = r;
        it.msg_direction = d;
        return it;
    endfunction

    function automatic out_item_t make_result(input logic [1:0] k, input logic [5:0] d,
                                              input logic [31:0] s, input logic [1:0] dir,
                                              input logic g, input logic [1:0] gn,
                                              input logic dr);
        out_item_t o;
        o = '{send_kind: k, send_dest: d, send_stamp: s, send_direction: dir,
              granted: g, gate_now: gn, dropped: dr};
        return o;
    endfunction

    task automatic add_row(input in_item_t it, input bit typed, input out_item_t w);
        row_t r;
        r.beat = it;
        r.typed = typed;
        r.want = w;
        rows.push_back(r);
    endtask

    // random event, mostly well-formed protocol traffic
    function automatic in_item_t random_event();
        int sel;
        logic [31:0] s;
        sel = $urandom_range(0, 99);
        s = ($urandom_range(0, 19) == 0) ? $urandom() : m_clock + $urandom_range(0, 20);
        if (sel < 15)
            return make_event(KIND_OWN_REQ, $urandom(), 6'($urandom()), 2'($urandom()));
        if (sel < 45)
            return make_event(KIND_REM_REQ, s, 6'($urandom_range(0, 7)),
                              2'(($urandom_range(0, 9) == 0) ? $urandom()
                                                            : $urandom_range(1, 2)));
        if (sel < 65)
            return make_event(KIND_ACK, s, 6'($urandom()), 2'($urandom()));
        if (sel < 83)
            return make_event(KIND_RELEASE, s,
                              ($urandom_range(0, 4) == 0) ? 6'($urandom())
                              : (m_fill != 0 ? m_queue[$urandom_range(0, m_fill-1)].rank
                                             : 6'd0), 2'($urandom()));
        if (sel < 95)
            return make_event(KIND_LEAVE, $urandom(), 6'($urandom()), 2'($urandom()));
        return make_event(3'($urandom_range(5, 7)), $urandom(), 6'($urandom()),
                          2'($urandom()));
    endfunction

    task automatic random_phase(input int n, input bit gaps);
        out_item_t none;
        none = '0;
        for (int i = 0; i < n; i++)
        begin
            // drain a full queue now and then so grants can form
            if (m_fill >= QUEUE_DEPTH && $urandom_range(0, 1) == 0)
                send_event(make_event(KIND_RELEASE, m_clock, m_queue[0].rank, 2'd0), 0, none,
                           gaps);
            else
                send_event(random_event(), 0, none, gaps);
        end
    endtask

    // ends a run that hangs
    initial
    begin
        #20ms;
        $display("TEST FAILED");
        $finish;
    end

    initial
    begin
        out_item_t none;
        none = '0;
        fail_count = 0;
        rst_n = 1'b0;
        start = 1'b0;
        item = '0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        m_rank = 6'd0;
        m_nodes = 7'd2;
        m_dir = 2'd1;
        m_cap = 5'd2;
        m_clock = '0;
        m_acks = '0;
        m_fill = 0;
        m_gate = 2'd0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed rows from reset defaults
        add_row(make_event(KIND_ACK, 32'd0, 6'd0, 2'd0), 1,
                make_result(SEND_NONE, 6'd0, 32'd0, 2'd0, 1'b0, 2'd0, 1'b0));
        add_row(make_event(KIND_RELEASE, 32'd5, 6'd63, 2'd0), 1,
                make_result(SEND_NONE, 6'd0, 32'd0, 2'd0, 1'b0, 2'd0, 1'b0));
        add_row(make_event(3'd7, 32'hFFFF_FFFF, 6'd63, 2'd3), 1,
                make_result(SEND_NONE, 6'd0, 32'd0, 2'd0, 1'b0, 2'd0, 1'b0));
        add_row(make_event(KIND_OWN_REQ, 32'd0, 6'd0, 2'd0), 0, none);
        add_row(make_event(KIND_ACK, 32'd1, 6'd1, 2'd0), 0, none);
        add_row(make_event(KIND_REM_REQ, 32'd2, 6'd63, 2'd3), 0, none);
        add_row(make_event(KIND_REM_REQ, 32'd2, 6'd63, 2'd0), 0, none);
        add_row(make_event(KIND_RELEASE, 32'd9, 6'd63, 2'd0), 0, none);
        add_row(make_event(KIND_LEAVE, 32'd0, 6'd0, 2'd0), 0, none);
        add_row(make_event(KIND_RELEASE, 32'd9, 6'd63, 2'd0), 0, none);
        add_row(make_event(3'd5, 32'd0, 6'd0, 2'd1), 0, none);
        add_row(make_event(3'd6, 32'd0, 6'd0, 2'd2), 0, none);
        // fill the queue past its depth, then saturate the clock
        for (int i = 0; i < 17; i++)
            add_row(make_event(KIND_REM_REQ, 32'd100, 6'(i), 2'd2), 0, none);
        add_row(make_event(KIND_ACK, 32'hFFFF_FFFF, 6'd1, 2'd1), 0, none);
        add_row(make_event(KIND_LEAVE, 32'd0, 6'd0, 2'd0), 0, none);
        foreach (rows[i])
            send_event(rows[i].beat, rows[i].typed, rows[i].want, 1'b0);

        // clear the queue, then walk configurations including extremes
        for (int i = 0; i < 17; i++)
            send_event(make_event(KIND_RELEASE, 32'd0, 6'(i), 2'd0), 0, none, 1'b1);
        // saturate the ack count with a node count of zero
        write_reg(CFG_NODE_COUNT, 7'd0);
        for (int i = 0; i < 130; i++)
            send_event(make_event(KIND_ACK, 32'd0, 6'd3, 2'd1), 0, none, 1'b0);
        random_phase(150, 1'b1);
        write_reg(CFG_OWN_RANK, 7'd63);
        write_reg(CFG_NODE_COUNT, 7'd64);
        write_reg(CFG_OWN_DIR, 7'd2);
        write_reg(CFG_GATE_CAP, 7'd16);
        random_phase(250, 1'b1);
        write_reg(CFG_OWN_RANK, 7'd3);
        write_reg(CFG_NODE_COUNT, 7'd1);
        write_reg(CFG_OWN_DIR, 7'd1);
        write_reg(CFG_GATE_CAP, 7'd1);
        random_phase(250, 1'b1);
        write_reg(CFG_OWN_RANK, 7'd5);
        write_reg(CFG_NODE_COUNT, 7'd3);
        write_reg(CFG_OWN_DIR, 7'd3);
        write_reg(CFG_GATE_CAP, 7'd0);
        random_phase(150, 1'b1);
        write_reg(CFG_OWN_RANK, 7'd2);
        write_reg(CFG_NODE_COUNT, 7'd127);
        write_reg(CFG_OWN_DIR, 7'd2);
        write_reg(CFG_GATE_CAP, 7'd31);
        random_phase(150, 1'b1);
        write_reg(CFG_OWN_RANK, 7'd1);
        write_reg(CFG_NODE_COUNT, 7'd2);
        write_reg(CFG_OWN_DIR, 7'd1);
        write_reg(CFG_GATE_CAP, 7'd2);
        random_phase(250, 1'b1);
        random_phase(100, 1'b0);

        // settle, then report
        repeat (50) @(posedge clk);
        if (fail_count == 0 && pending_results.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end
endmodule
